// ===== sv/gsg_pkg.sv =====
// ----------------------------------------------------------------------------
// gsg_pkg
// Shared types, constants and LFSR step functions for the Gold sequence
// generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gsg_pkg;

  // Words discarded after seeding (1600 bits at 32 bits per word).
  localparam int unsigned WARMUP_WORDS = 50;
  localparam int unsigned SKIP_MAX     = 255;
  // Counter holds WARMUP_WORDS - 1 + SKIP_MAX at most.
  localparam int unsigned CNT_W        = $clog2(WARMUP_WORDS + SKIP_MAX);

  // x1(0) = 1, x1(1..30) = 0, x1(31) = x1(3) ^ x1(0) = 1.
  localparam logic [31:0] X1_SEED = 32'h8000_0001;

  typedef struct packed {
    logic        start_req;
    logic [30:0] c_init;
    logic [7:0]  skip_words;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] seq_word;
    logic        last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;   // input beat accepted this cycle
    logic seed;   // load both windows and the warm-up counter
    logic step;   // advance one word and count down
    logic emit;   // advance one word and load the output register
  } gsg_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic cnt_zero;
    logic out_free;
  } gsg_status_t;

  // Window holds x(m..m+31) with x(m) in bit 31; return x(m+32..m+63).
  // x1(n+31) = x1(n+3) ^ x1(n)
  function automatic logic [31:0] adv_x1(input logic [31:0] w);
    logic [63:0] e;
    logic [31:0] r;
    for (int k = 0; k < 32; k++) e[k] = w[31-k];
    for (int k = 32; k < 64; k++) e[k] = e[k-28] ^ e[k-31];
    for (int j = 0; j < 32; j++) r[31-j] = e[32+j];
    return r;
  endfunction

  // x2(n+31) = x2(n+3) ^ x2(n+2) ^ x2(n+1) ^ x2(n)
  function automatic logic [31:0] adv_x2(input logic [31:0] w);
    logic [63:0] e;
    logic [31:0] r;
    for (int k = 0; k < 32; k++) e[k] = w[31-k];
    for (int k = 32; k < 64; k++) e[k] = e[k-28] ^ e[k-29] ^ e[k-30] ^ e[k-31];
    for (int j = 0; j < 32; j++) r[31-j] = e[32+j];
    return r;
  endfunction

  // Bit-reverse c_init into x2(0..30) and append x2(31).
  function automatic logic [31:0] seed_x2(input logic [30:0] c);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < 31; i++) w[31-i] = c[i];
    w[0] = w[31] ^ w[30] ^ w[29] ^ w[28];
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/gsg_datapath.sv =====
// ----------------------------------------------------------------------------
// gsg_datapath
// x1/x2 windows with one-word LFSR jump, warm-up counter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsg_datapath (
  input  wire                  clk,
  input  wire                  rst_n,
  input  gsg_pkg::in_item_t    in_data,
  input  gsg_pkg::gsg_cmd_t    cmd,
  output gsg_pkg::gsg_status_t status,
  output logic                 out_valid,
  input  wire                  out_stall,
  output gsg_pkg::out_item_t   out_data
);
  import gsg_pkg::*;

  logic [31:0]      x1_r, x1_nxt;
  logic [31:0]      x2_r, x2_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic [31:0]      x1_adv, x2_adv;

  always_comb begin
    x1_adv = adv_x1(x1_r);
    x2_adv = adv_x2(x2_r);
  end

  always_comb begin
    x1_nxt        = x1_r;
    x2_nxt        = x2_r;
    cnt_nxt       = cnt_r;
    last_nxt      = cmd.take ? in_data.last_word : last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.seed) begin
      x1_nxt  = X1_SEED;
      x2_nxt  = seed_x2(in_data.c_init);
      cnt_nxt = CNT_W'(WARMUP_WORDS - 1) + CNT_W'(in_data.skip_words);
    end else if (cmd.step || cmd.emit) begin
      x1_nxt = x1_adv;
      x2_nxt = x2_adv;
      if (cmd.step) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end

    if (cmd.emit) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.seq_word = x1_adv ^ x2_adv;
      out_data_nxt.last     = cmd.take ? in_data.last_word : last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r        <= '0;
      x2_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      x1_r        <= x1_nxt;
      x2_r        <= x2_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign status.cnt_zero = (cnt_r == '0);
  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

`default_nettype wire

// ===== sv/gsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsg_ctrl
// Sequencer: accept beats, run the warm-up count, issue emit commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsg_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_start,
  output logic                 in_stall,
  input  gsg_pkg::gsg_status_t status,
  output gsg_pkg::gsg_cmd_t    cmd,
  output logic                 busy
);
  import gsg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WARM = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = !status.out_free;
        if (in_valid && status.out_free) begin
          cmd.take = 1'b1;
          if (in_start) begin
            cmd.seed  = 1'b1;
            state_nxt = ST_WARM;
          end else begin
            cmd.emit = 1'b1;
          end
        end
      end
      ST_WARM: begin
        // count down the discarded words, then emit the first one kept
        if (!status.cnt_zero) begin
          cmd.step = 1'b1;
        end else if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r == ST_WARM);

endmodule

`default_nettype wire

// ===== sv/gold_sequence_generator_top.sv =====
// ----------------------------------------------------------------------------
// gold_sequence_generator_top
// Length-31 Gold scrambling sequence generator, 32 sequence bits per beat.
// ----------------------------------------------------------------------------
// Order: a continue beat gives its word in the cycle after acceptance; a start
//   beat seeds, counts the warm-up down, then emits once the output is free.
// Throughput: one continue beat per cycle, set by the one-word LFSR jump in
//   the datapath, if the output is free; a start beat holds input for warm-up.
// Reset: synchronous active-low; clears both windows (words read 0 until the
//   first start), the warm-up counter, the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module gold_sequence_generator_top (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  gsg_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output gsg_pkg::out_item_t out_data
);
  import gsg_pkg::*;

  gsg_cmd_t    cmd;
  gsg_status_t status;
  logic        ctrl_busy;

  // Sequencer: decide when to take a beat and what the datapath does.
  gsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_start (in_data.start_req),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .busy     (ctrl_busy)
  );

  // Windows, warm-up counter and output register.
  gsg_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A beat is taken only when the output register is free this cycle.
  a_accept_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (!out_valid || !out_stall))
    else $error("input beat taken while output register blocked");

  // A continue beat shows its word in the next cycle.
  a_continue_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_data.start_req) |=> out_valid)
    else $error("continue beat gave no word");

  // A start beat never shows a word in the next cycle: warm-up comes first.
  a_start_warms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.start_req) |=> !out_valid)
    else $error("word shown before warm-up");

  // Hold the input during warm-up.
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_busy |-> in_stall)
    else $error("input open during warm-up");

endmodule

`default_nettype wire
